// File: src/rv32s_pkg.sv
// Package: shared constants, opcodes, status codes and types for the RV32 subset core.
`timescale 1ns / 1ps
package rv32s_pkg;
    localparam int DATA_BYTES = 4096;
    localparam int DADDR_W = $clog2(DATA_BYTES);

    localparam logic [6:0] OP_R    = 7'h33;
    localparam logic [6:0] OP_I    = 7'h13;
    localparam logic [6:0] OP_LD   = 7'h03;
    localparam logic [6:0] OP_ST   = 7'h23;
    localparam logic [6:0] OP_BR   = 7'h63;
    localparam logic [6:0] OP_JAL  = 7'h6F;
    localparam logic [6:0] OP_JALR = 7'h67;
    localparam logic [6:0] OP_LUI  = 7'h37;
    localparam logic [6:0] OP_AUI  = 7'h17;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_TERM   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_UNALN  = 3'd3;
    localparam logic [2:0] ST_UNSUP  = 3'd4;
    localparam logic [2:0] ST_HALTED = 3'd5;

    localparam logic [1:0] SOP_ADD = 2'd0;
    localparam logic [1:0] SOP_SUB = 2'd1;
    localparam logic [1:0] SOP_MUL = 2'd2;
    localparam logic [1:0] SOP_DIV = 2'd3;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic        want_rem;
        logic [31:0] a;
        logic [31:0] b;
    } t_ser_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_ser_rsp;
endpackage

// File: src/rv32s_serial_alu.sv
// Bit-serial arithmetic unit: add, subtract, shift-add multiply and restoring divide.
`timescale 1ns / 1ps
module rv32s_serial_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rv32s_pkg::t_ser_req  i_req,
    output rv32s_pkg::t_ser_rsp  o_rsp
);
    logic        r_busy, n_busy;
    logic [1:0]  r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_acc, n_acc;
    logic        r_cy, n_cy;
    logic        r_rem, n_rem;
    logic        r_na, n_na;
    logic        r_nq, n_nq;
    logic        r_bz, n_bz;
    logic [31:0] r_orig, n_orig;
    logic        r_done, n_done;
    logic [31:0] r_res, n_res;

    logic [1:0]  sum2;
    logic [32:0] trial;
    logic [31:0] ma, mb, q, rm;

    always_comb begin
        n_busy = r_busy; n_op = r_op; n_cnt = r_cnt; n_a = r_a; n_b = r_b;
        n_acc = r_acc; n_cy = r_cy; n_rem = r_rem; n_na = r_na; n_nq = r_nq;
        n_bz = r_bz; n_orig = r_orig; n_done = 1'b0; n_res = r_res;
        sum2 = 2'd0; trial = 33'd0;
        ma = i_req.a[31] ? 32'd0 - i_req.a : i_req.a;
        mb = i_req.b[31] ? 32'd0 - i_req.b : i_req.b;
        q = r_a; rm = r_acc;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1; n_op = i_req.op; n_cnt = 6'd0; n_acc = 32'd0;
                n_rem = i_req.want_rem; n_orig = i_req.a; n_bz = (i_req.b == 32'd0);
                n_na = i_req.a[31]; n_nq = i_req.a[31] ^ i_req.b[31];
                n_cy = (i_req.op == rv32s_pkg::SOP_SUB);
                n_a = i_req.a; n_b = i_req.b;
                if (i_req.op == rv32s_pkg::SOP_SUB) n_b = ~i_req.b;
                if (i_req.op == rv32s_pkg::SOP_DIV) begin
                    n_a = ma; n_b = mb;
                end
            end
        end else begin
            unique case (r_op)
                rv32s_pkg::SOP_ADD, rv32s_pkg::SOP_SUB: begin
                    sum2 = {1'b0, r_a[0]} + {1'b0, r_b[0]} + {1'b0, r_cy};
                    n_cy = sum2[1];
                    n_acc = {sum2[0], r_acc[31:1]};
                    n_a = r_a >> 1; n_b = r_b >> 1;
                end
                rv32s_pkg::SOP_MUL: begin
                    if (r_b[0]) n_acc = r_acc + r_a;
                    n_a = r_a << 1; n_b = r_b >> 1;
                end
                default: begin
                    trial = {r_acc, r_a[31]} - {1'b0, r_b};
                    if (!trial[32]) begin
                        n_acc = trial[31:0]; n_a = {r_a[30:0], 1'b1};
                    end else begin
                        n_acc = {r_acc[30:0], r_a[31]}; n_a = {r_a[30:0], 1'b0};
                    end
                end
            endcase
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
                q = n_a; rm = n_acc;
                unique case (r_op)
                    rv32s_pkg::SOP_DIV: begin
                        if (r_bz) n_res = r_rem ? r_orig : 32'hFFFFFFFF;
                        else if (r_rem) n_res = r_na ? 32'd0 - rm : rm;
                        else n_res = r_nq ? 32'd0 - q : q;
                    end
                    default: n_res = n_acc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_op <= n_op; r_cnt <= n_cnt; r_a <= n_a; r_b <= n_b; r_acc <= n_acc;
        r_cy <= n_cy; r_rem <= n_rem; r_na <= n_na; r_nq <= n_nq; r_bz <= n_bz;
        r_orig <= n_orig; r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.result = r_res;
endmodule

// File: src/rv32_subset_single_cycle_core_unit.sv
// Top level: RV32 subset executor with register file, byte data store and serial datapath.
`timescale 1ns / 1ps
// Executes one instruction word per transfer against an internal register file, PC and
// byte data store. Address and arithmetic adds, and MUL/DIV/REM, run through a bit-serial
// unit; stores move one byte per cycle over the data store port, and loads read each
// byte through the S_MEM and S_MEMW states. After reset a clearing pass zeroes the
// register file and data store before the first transfer.
module rv32_subset_single_cycle_core_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_instr_pc,
    output logic [31:0] o_following_pc,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic        o_dest_written,
    output logic [2:0]  o_status
);
    localparam int AW = rv32s_pkg::DADDR_W;
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_DEC = 4'd3,
        S_A1 = 4'd4, S_A1W = 4'd5, S_MEM = 4'd6, S_MEMW = 4'd7, S_FIN = 4'd8,
        S_OUT = 4'd9, S_A2 = 4'd10, S_A2W = 4'd11;

    logic [3:0]  r_st, n_st;
    logic [AW:0] r_clr, n_clr;
    logic [31:0] r_pc, n_pc;
    logic        r_halt, n_halt;
    logic [31:0] r_w, n_w;
    logic [31:0] r_a, r_b;
    logic [31:0] r_val, n_val;
    logic [31:0] r_nxt, n_nxt;
    logic [31:0] r_addr, n_addr;
    logic [2:0]  r_bi, n_bi;
    logic        r_ov, n_ov;
    logic [31:0] r_opc, n_opc, r_onx, n_onx, r_ovl, n_ovl;
    logic [4:0]  r_oix, n_oix;
    logic        r_owr, n_owr;
    logic [2:0]  r_ost, n_ost;
    logic [2:0]  r_oss, n_oss;

    logic [31:0] r_rf [32];
    logic [7:0]  r_mem [rv32s_pkg::DATA_BYTES];
    logic [7:0]  r_mrd;
    logic        rf_we, m_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic [AW-1:0] m_a;
    logic [7:0]  m_wd;

    rv32s_pkg::t_ser_req sreq;
    rv32s_pkg::t_ser_rsp srsp;

    rv32s_serial_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sreq), .o_rsp(srsp));

    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] immi, imms, immb, immj, upi;
    logic [1:0]  nbytes;
    logic [4:0]  sh;
    logic        lts, take;

    assign op = r_w[6:0];
    assign rd = r_w[11:7];
    assign f3 = r_w[14:12];
    assign f7 = r_w[31:25];
    assign immi = {{20{r_w[31]}}, r_w[31:20]};
    assign imms = {{20{r_w[31]}}, r_w[31:25], r_w[11:7]};
    assign immb = {{19{r_w[31]}}, r_w[31], r_w[7], r_w[30:25], r_w[11:8], 1'b0};
    assign immj = {{11{r_w[31]}}, r_w[31], r_w[19:12], r_w[20], r_w[30:21], 1'b0};
    assign upi = {r_w[31:12], 12'd0};
    assign nbytes = f3[1:0];
    assign sh = r_b[4:0];
    assign lts = $signed(r_a) < $signed(r_b);

    always_comb begin
        unique case (f3)
            3'd0: take = r_a == r_b;
            3'd1: take = r_a != r_b;
            3'd4: take = lts;
            3'd5: take = !lts;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_pc = r_pc; n_halt = r_halt; n_w = r_w;
        n_val = r_val; n_nxt = r_nxt; n_addr = r_addr; n_bi = r_bi; n_ov = r_ov;
        n_opc = r_opc; n_onx = r_onx; n_ovl = r_ovl; n_oix = r_oix; n_owr = r_owr;
        n_ost = r_ost; n_oss = r_oss;
        sreq = '0;
        rf_we = 1'b0; rf_wa = rd; rf_wd = r_val;
        m_we = 1'b0; m_a = r_addr[AW-1:0]; m_wd = 8'd0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_st)
            S_CLR: begin
                rf_we = 1'b1; rf_wa = r_clr[4:0]; rf_wd = 32'd0;
                m_we = 1'b1; m_a = r_clr[AW-1:0];
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(rv32s_pkg::DATA_BYTES - 1)) n_st = S_IDLE;
            end
            S_IDLE: if (i_valid) begin
                n_w = i_instr_word; n_st = S_RD;
            end
            S_RD: n_st = S_DEC;
            S_DEC: begin
                n_nxt = r_pc + 32'd4; n_val = 32'd0; n_bi = 3'd0;
                n_ost = rv32s_pkg::ST_OK; n_st = S_FIN;
                if (r_halt) n_ost = rv32s_pkg::ST_HALTED;
                else if (r_pc[1:0] != 2'd0) n_ost = rv32s_pkg::ST_UNALN;
                else if (r_w == 32'hFFFFFFFF) n_ost = rv32s_pkg::ST_TERM;
                else if (r_w == 32'd0) n_ost = rv32s_pkg::ST_ZERO;
                else begin
                    unique case (op)
                        rv32s_pkg::OP_R: begin
                            unique case (f3)
                                3'd0: begin
                                    if (f7 == 7'h00 || f7 == 7'h20 || f7 == 7'h01)
                                        n_st = S_A1;
                                end
                                3'd1: n_val = r_a << sh;
                                3'd2: n_val = {31'd0, lts};
                                3'd3: n_ost = rv32s_pkg::ST_UNSUP;
                                3'd4: begin
                                    if (f7 == 7'h00) n_val = r_a ^ r_b;
                                    else if (f7 == 7'h01) n_st = S_A1;
                                end
                                3'd5: begin
                                    if (f7 == 7'h00) n_val = r_a >> sh;
                                    else if (f7 == 7'h20) n_val = $unsigned($signed(r_a) >>> sh);
                                end
                                3'd6: begin
                                    if (f7 == 7'h00) n_val = r_a | r_b;
                                    else if (f7 == 7'h01) n_st = S_A1;
                                end
                                default: n_val = r_a & r_b;
                            endcase
                        end
                        rv32s_pkg::OP_I: begin
                            if (f3 == 3'd0) n_st = S_A1;
                            else if (f3 == 3'd7) n_val = r_a & immi;
                            else if (f3 == 3'd6) n_val = r_a | immi;
                            else n_ost = rv32s_pkg::ST_UNSUP;
                        end
                        rv32s_pkg::OP_LD, rv32s_pkg::OP_ST: begin
                            if (f3 <= 3'd2) n_st = S_A1;
                            else n_ost = rv32s_pkg::ST_UNSUP;
                        end
                        rv32s_pkg::OP_BR: if (take) n_nxt = r_pc + immb;
                        rv32s_pkg::OP_JAL: begin
                            n_val = r_pc + 32'd4; n_nxt = r_pc + immj;
                        end
                        rv32s_pkg::OP_JALR: begin
                            n_val = r_pc + 32'd4; n_st = S_A2;
                        end
                        rv32s_pkg::OP_LUI: n_val = upi;
                        rv32s_pkg::OP_AUI: n_val = r_pc + upi;
                        default: n_ost = rv32s_pkg::ST_UNSUP;
                    endcase
                end
            end
            S_A1: begin
                sreq.start = 1'b1; sreq.a = r_a; sreq.want_rem = f3[1];
                sreq.b = (op == rv32s_pkg::OP_R) ? r_b :
                         (op == rv32s_pkg::OP_ST) ? imms : immi;
                sreq.op = rv32s_pkg::SOP_ADD;
                if (op == rv32s_pkg::OP_R) begin
                    if (f3 != 3'd0) sreq.op = rv32s_pkg::SOP_DIV;
                    else if (f7 == 7'h20) sreq.op = rv32s_pkg::SOP_SUB;
                    else if (f7 == 7'h01) sreq.op = rv32s_pkg::SOP_MUL;
                end
                n_st = S_A1W;
            end
            S_A1W: if (srsp.done) begin
                if (op == rv32s_pkg::OP_LD || op == rv32s_pkg::OP_ST) begin
                    n_addr = srsp.result; n_st = S_MEM;
                end else begin
                    n_val = srsp.result; n_st = S_FIN;
                end
            end
            S_A2: begin
                sreq.start = 1'b1; sreq.a = r_a; sreq.b = immi;
                sreq.op = rv32s_pkg::SOP_ADD; n_st = S_A2W;
            end
            S_A2W: if (srsp.done) begin
                n_nxt = {srsp.result[31:1], 1'b0}; n_st = S_FIN;
            end
            S_MEM: begin
                if (op == rv32s_pkg::OP_ST) begin
                    m_we = 1'b1; m_wd = r_b[8*r_bi[1:0] +: 8];
                    n_addr = r_addr + 32'd1; n_bi = r_bi + 3'd1;
                    if (r_bi[1:0] == ((2'd1 << nbytes) - 2'd1)) n_st = S_FIN;
                end else n_st = S_MEMW;
            end
            S_MEMW: begin
                n_val[8*r_bi[1:0] +: 8] = r_mrd;
                n_addr = r_addr + 32'd1; n_bi = r_bi + 3'd1; n_st = S_MEM;
                if (r_bi[1:0] == ((2'd1 << nbytes) - 2'd1)) begin
                    n_st = S_FIN;
                    if (nbytes == 2'd0) n_val = {{24{r_mrd[7]}}, r_mrd};
                    else if (nbytes == 2'd1) n_val = {{16{r_mrd[7]}}, r_mrd, r_val[7:0]};
                end
            end
            S_FIN: if (!r_ov || !i_stall) begin
                n_ov = 1'b1; n_opc = r_pc; n_oss = r_ost;
                if (r_ost != rv32s_pkg::ST_OK) begin
                    if (r_ost != rv32s_pkg::ST_HALTED) n_halt = 1'b1;
                    n_onx = r_pc; n_oix = 5'd0; n_ovl = 32'd0; n_owr = 1'b0;
                end else begin
                    if (op == rv32s_pkg::OP_ST || op == rv32s_pkg::OP_BR) begin
                        n_oix = 5'd0; n_ovl = 32'd0; n_owr = 1'b0;
                    end else begin
                        n_oix = rd; n_ovl = r_val; n_owr = (rd != 5'd0);
                        rf_we = (rd != 5'd0);
                    end
                    n_onx = r_nxt; n_pc = r_nxt;
                end
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_wa] <= rf_wd;
        r_a <= (r_w[19:15] == 5'd0) ? 32'd0 : r_rf[r_w[19:15]];
        r_b <= (r_w[24:20] == 5'd0) ? 32'd0 : r_rf[r_w[24:20]];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) r_mem[m_a] <= m_wd;
        r_mrd <= r_mem[m_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_pc <= 32'd0; r_halt <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_clr <= n_clr; r_pc <= n_pc; r_halt <= n_halt; r_ov <= n_ov;
        end
        r_w <= n_w; r_val <= n_val; r_nxt <= n_nxt; r_addr <= n_addr; r_bi <= n_bi;
        r_opc <= n_opc; r_onx <= n_onx; r_ovl <= n_ovl; r_oix <= n_oix;
        r_owr <= n_owr; r_ost <= n_ost; r_oss <= n_oss;
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_instr_pc = r_opc;
    assign o_following_pc = r_onx;
    assign o_dest_index = r_oix;
    assign o_dest_value = r_ovl;
    assign o_dest_written = r_owr;
    assign o_status = r_oss;
endmodule

// File: src/rv32s_checker.sv
// Port-level checker for the RV32 subset core, bound to the top level.
`timescale 1ns / 1ps
module rv32s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_instr_pc,
    input logic [31:0] o_following_pc,
    input logic [4:0]  o_dest_index,
    input logic        o_dest_written,
    input logic [2:0]  o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_instr_pc))
        else $error("stalled transfer changed");
    a_wr0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dest_written |-> o_dest_index != 5'd0)
        else $error("write to x0 reported");
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rv32s_pkg::ST_OK |-> o_following_pc == o_instr_pc
            && !o_dest_written)
        else $error("halting transfer moved pc or wrote");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= rv32s_pkg::ST_HALTED)
        else $error("bad status");
endmodule

bind rv32_subset_single_cycle_core_unit rv32s_checker u_chk (.*);
